// ===== src/rsaf_pkg.sv =====
// Package for the reflective sensor ambient filter.
// Holds the field widths, phase and emitter group codes, and the shared adder request type.
// Has no dependencies; used by every other file of the block but rsaf_ram.
package rsaf_pkg;

  localparam int NUM_SENSORS = 6;
  localparam int SAMPLE_W    = 12;
  localparam int LEVEL_W     = 8;
  localparam int DIFF_W      = 9;
  localparam int CHANGE_W    = 10;
  localparam int SUM_OUT_W   = 13;
  localparam int DSUM_W      = 13;
  localparam int ALU_W       = 14;
  localparam int MAG_W       = 12;
  localparam int QUO_W       = 8;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int CHAN_W      = 3;

  localparam int IN_DATA_W   = NUM_SENSORS * SAMPLE_W;
  localparam int OUT_DATA_W  = 40;
  localparam int OUT_USER_W  = 4;

  // Phase codes of the sensing sequence.
  localparam logic [2:0] PH_AMBIENT = 3'd0;
  localparam logic [2:0] PH_FRONT   = 3'd1;
  localparam logic [2:0] PH_MIDDLE  = 3'd2;
  localparam logic [2:0] PH_SIDE    = 3'd3;
  localparam logic [2:0] PH_FILTER  = 3'd4;

  // Emitter groups, coded like the low bits of the phase that lights them.
  localparam logic [1:0] GRP_FRONT  = 2'd1;
  localparam logic [1:0] GRP_MIDDLE = 2'd2;
  localparam logic [1:0] GRP_SIDE   = 2'd3;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  function automatic logic [1:0] rsaf_group(input int idx);
    logic [1:0] g;
    case (idx)
      0, 5:    g = GRP_FRONT;
      1, 4:    g = GRP_MIDDLE;
      default: g = GRP_SIDE;
    endcase
    return g;
  endfunction

endpackage

// ===== src/rsaf_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the difference and change rings.
module rsaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rsaf_alu.sv =====
// Shared add/subtract unit of the filter sequencer.
// Depends on rsaf_pkg for the request type and the datapath width.
module rsaf_alu (
  input  rsaf_pkg::alu_req_t        req,
  output logic [rsaf_pkg::ALU_W-1:0] y
);
  import rsaf_pkg::*;

  // Modular arithmetic: intermediate wraps cancel in the running sums.
  always_comb begin
    if (req.sub) begin
      y = req.a - req.b;
    end else begin
      y = req.a + req.b;
    end
  end

endmodule

// ===== src/rsaf_recip_mul.sv =====
// Registered reciprocal multiplier that divides a ring sum magnitude by the ring depth.
// Depends on rsaf_pkg for widths; exact for every magnitude below 4096 and depths up to 16.
module rsaf_recip_mul #(
  parameter int DIVISOR = 5
) (
  input  logic                        clk,
  input  logic [rsaf_pkg::MAG_W-1:0]  mag,
  output logic [rsaf_pkg::QUO_W-1:0]  quo
);
  import rsaf_pkg::*;

  localparam int PROD_W = MAG_W + RECIP_W;
  localparam int RECIP  = ((2 ** RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;

  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mag) * PROD_W'(RECIP);
  end

  assign quo = prod[RECIP_SHIFT +: QUO_W];

endmodule

// ===== src/reflective_sensor_ambient_filter.sv =====
// Top level of the reflective sensor ambient filter: phase sequencer and filter datapath.
// Depends on rsaf_pkg, rsaf_ram, rsaf_alu and rsaf_recip_mul.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_tvalid, s_tready | s_tdata: six 12-bit samples
//   m_      | out       | m_tvalid, m_tready | m_tdata, m_tuser, m_tlast
//
// A sensing phase is the accepting cycle and the EMIT state, which loads the output register.
// In the filter phase each channel steps through READ, SUB, ADD, ABS, MUL, QUO, CHG, NEG,
// CS1, CS2 and EMIT, as it uses the shared adder nine times and the registered multiplier.
// Reset clears control and per-channel state; the rings are masked by fill counts instead.
// A result that waits on m_tready holds the sequencer; s_tready is high only when idle.
module reflective_sensor_ambient_filter #(
  parameter int CHANNELS      = 6,
  parameter int AVERAGE_DEPTH = 5,
  parameter int SUM_DEPTH     = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // raw_left_front, raw_left_middle, raw_left_side, raw_right_side,
  // raw_right_middle, raw_right_front (12 bits each, lowest first)
  input  logic [rsaf_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // led_front, led_middle, led_side, level[9], change[10], change_sum[13], zero fill[5]
  output logic [rsaf_pkg::OUT_DATA_W-1:0]   m_tdata,
  // has_channel, channel[3]
  output logic [rsaf_pkg::OUT_USER_W-1:0]   m_tuser,
  output logic                              m_tlast
);
  import rsaf_pkg::*;

  localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DSW    = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int DFW    = $clog2(AVERAGE_DEPTH + 1);
  localparam int CSW    = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
  localparam int CFW    = $clog2(SUM_DEPTH + 1);
  localparam int DDEPTH = CHANNELS * AVERAGE_DEPTH;
  localparam int CDEPTH = CHANNELS * SUM_DEPTH;
  localparam int DAW    = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_READ = 4'd1;
  localparam logic [3:0] ST_SUB  = 4'd2;
  localparam logic [3:0] ST_ADD  = 4'd3;
  localparam logic [3:0] ST_ABS  = 4'd4;
  localparam logic [3:0] ST_MUL  = 4'd5;
  localparam logic [3:0] ST_QUO  = 4'd6;
  localparam logic [3:0] ST_CHG  = 4'd7;
  localparam logic [3:0] ST_NEG  = 4'd8;
  localparam logic [3:0] ST_CS1  = 4'd9;
  localparam logic [3:0] ST_CS2  = 4'd10;
  localparam logic [3:0] ST_EMIT = 4'd11;

  logic [3:0]                  state;
  logic [2:0]                  phase;
  logic                        filt;
  logic [CW-1:0]               ch;
  logic [DSW-1:0]              dslot;
  logic [DFW-1:0]              dfill;
  logic [CSW-1:0]              cslot;
  logic [CFW-1:0]              cfill;

  logic [LEVEL_W-1:0]          ambient [CHANNELS];
  logic [LEVEL_W-1:0]          lit     [CHANNELS];
  logic signed [DSUM_W-1:0]    dsum    [CHANNELS];
  logic signed [ALU_W-1:0]     csum    [CHANNELS];
  logic signed [DIFF_W-1:0]    avg     [CHANNELS];

  logic signed [DIFF_W-1:0]    diff;
  logic signed [ALU_W-1:0]     tmp;
  logic [MAG_W-1:0]            mag;
  logic                        negq;
  logic signed [DIFF_W-1:0]    avg_new;
  logic signed [CHANGE_W-1:0]  chg;
  logic signed [CHANGE_W-1:0]  newc;
  logic signed [CHANGE_W-1:0]  oldc;

  logic                        out_valid;
  logic [2:0]                  out_led;
  logic                        out_has;
  logic [CHAN_W-1:0]           out_ch;
  logic [DIFF_W-1:0]           out_level;
  logic [CHANGE_W-1:0]         out_chg;
  logic [SUM_OUT_W-1:0]        out_sum;
  logic                        out_last;

  logic [DAW-1:0]              d_addr;
  logic [CAW-1:0]              c_addr;
  logic [DIFF_W-1:0]           d_rdata;
  logic [CHANGE_W-1:0]         c_rdata;
  logic signed [DIFF_W-1:0]    d_old;
  logic signed [CHANGE_W-1:0]  c_old;
  logic [QUO_W-1:0]            quo;
  alu_req_t                    req;
  logic [ALU_W-1:0]            alu_y;
  logic                        out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !out_valid || m_tready;

  assign d_addr = DAW'(ch) * DAW'(AVERAGE_DEPTH) + DAW'(dslot);
  assign c_addr = CAW'(ch) * CAW'(SUM_DEPTH) + CAW'(cslot);

  // Ring entries not yet written since reset read as zero.
  assign d_old = (DFW'(dslot) < dfill) ? d_rdata : '0;
  assign c_old = (CFW'(cslot) < cfill) ? c_rdata : '0;

  rsaf_ram #(.WIDTH(DIFF_W), .DEPTH(DDEPTH)) u_diff_ring (
    .clk   (clk),
    .we    (state == ST_SUB),
    .waddr (d_addr),
    .wdata (diff),
    .raddr (d_addr),
    .rdata (d_rdata)
  );

  rsaf_ram #(.WIDTH(CHANGE_W), .DEPTH(CDEPTH)) u_change_ring (
    .clk   (clk),
    .we    (state == ST_CS1),
    .waddr (c_addr),
    .wdata (newc),
    .raddr (c_addr),
    .rdata (c_rdata)
  );

  rsaf_recip_mul #(.DIVISOR(AVERAGE_DEPTH)) u_recip_mul (
    .clk (clk),
    .mag (mag),
    .quo (quo)
  );

  rsaf_alu u_alu (
    .req (req),
    .y   (alu_y)
  );

  always_comb begin
    req.a   = '0;
    req.b   = '0;
    req.sub = 1'b0;
    case (state)
      ST_READ: begin
        req.a   = ALU_W'(lit[ch]);
        req.b   = ALU_W'(ambient[ch]);
        req.sub = 1'b1;
      end
      ST_SUB: begin
        req.a   = ALU_W'(dsum[ch]);
        req.b   = ALU_W'(d_old);
        req.sub = 1'b1;
      end
      ST_ADD: begin
        req.a = tmp;
        req.b = ALU_W'(diff);
      end
      ST_ABS: begin
        req.b   = tmp;
        req.sub = tmp[ALU_W-1];
      end
      ST_QUO: begin
        req.b   = ALU_W'(quo);
        req.sub = negq;
      end
      ST_CHG: begin
        req.a   = ALU_W'(avg_new);
        req.b   = ALU_W'(avg[ch]);
        req.sub = 1'b1;
      end
      ST_NEG: begin
        req.a   = ALU_W'(avg[ch]);
        req.b   = ALU_W'(avg_new);
        req.sub = 1'b1;
      end
      ST_CS1: begin
        req.a   = csum[ch];
        req.b   = ALU_W'(oldc);
        req.sub = 1'b1;
      end
      ST_CS2: begin
        req.a = tmp;
        req.b = ALU_W'(newc);
      end
      default: begin
        req.sub = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_AMBIENT;
      filt      <= 1'b0;
      ch        <= '0;
      dslot     <= '0;
      dfill     <= '0;
      cslot     <= '0;
      cfill     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        ambient[i] <= '0;
        lit[i]     <= '0;
        dsum[i]    <= '0;
        csum[i]    <= '0;
        avg[i]     <= '0;
      end
    end else begin
      // In the emit state the output register is reloaded below instead.
      if (out_valid && m_tready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (!phase[2]) begin
              for (int i = 0; i < CHANNELS; i++) begin
                if (phase == PH_AMBIENT) begin
                  ambient[i] <= s_tdata[i*SAMPLE_W + 4 +: LEVEL_W];
                end else if (rsaf_group(i) == phase[1:0]) begin
                  lit[i] <= s_tdata[i*SAMPLE_W + 4 +: LEVEL_W];
                end
              end
              phase <= phase + 3'd1;
              filt  <= 1'b0;
              state <= ST_EMIT;
            end else begin
              phase <= PH_AMBIENT;
              filt  <= 1'b1;
              ch    <= '0;
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          diff  <= alu_y[DIFF_W-1:0];
          state <= ST_SUB;
        end
        ST_SUB: begin
          tmp   <= alu_y;
          oldc  <= c_old;
          state <= ST_ADD;
        end
        ST_ADD: begin
          dsum[ch] <= alu_y[DSUM_W-1:0];
          tmp      <= alu_y;
          state    <= ST_ABS;
        end
        ST_ABS: begin
          mag   <= alu_y[MAG_W-1:0];
          negq  <= tmp[ALU_W-1];
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_QUO;
        end
        ST_QUO: begin
          avg_new <= alu_y[DIFF_W-1:0];
          state   <= ST_CHG;
        end
        ST_CHG: begin
          chg   <= alu_y[CHANGE_W-1:0];
          state <= ST_NEG;
        end
        ST_NEG: begin
          newc  <= alu_y[CHANGE_W-1:0];
          state <= ST_CS1;
        end
        ST_CS1: begin
          tmp   <= alu_y;
          state <= ST_CS2;
        end
        ST_CS2: begin
          csum[ch] <= alu_y;
          tmp      <= alu_y;
          avg[ch]  <= avg_new;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            // The phase register already holds the next phase here.
            out_led   <= {(phase == PH_SIDE) || (phase == PH_FILTER),
                          phase == PH_MIDDLE, phase == PH_FRONT};
            out_has   <= filt;
            if (filt) begin
              out_ch    <= CHAN_W'(ch);
              out_level <= avg_new;
              out_chg   <= chg;
              out_sum   <= tmp[SUM_OUT_W-1:0];
              out_last  <= (ch == CW'(CHANNELS - 1));
              if (ch == CW'(CHANNELS - 1)) begin
                dslot <= (dslot == DSW'(AVERAGE_DEPTH - 1)) ? '0 : dslot + 1'b1;
                cslot <= (cslot == CSW'(SUM_DEPTH - 1)) ? '0 : cslot + 1'b1;
                if (dfill != DFW'(AVERAGE_DEPTH)) begin
                  dfill <= dfill + 1'b1;
                end
                if (cfill != CFW'(SUM_DEPTH)) begin
                  cfill <= cfill + 1'b1;
                end
                state <= ST_IDLE;
              end else begin
                ch    <= ch + 1'b1;
                state <= ST_READ;
              end
            end else begin
              out_ch    <= '0;
              out_level <= '0;
              out_chg   <= '0;
              out_sum   <= '0;
              out_last  <= 1'b1;
              state     <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_sum, out_chg, out_level, out_led};
  assign m_tuser  = {out_ch, out_has};
  assign m_tlast  = out_last;

endmodule

// ===== src/rsaf_checker.sv =====
// Port-level checker for the reflective sensor ambient filter, bound to the top level.
// Depends on rsaf_pkg for the port widths.
module rsaf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rsaf_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [rsaf_pkg::OUT_USER_W-1:0] m_tuser,
  input logic                            m_tlast
);

  // An accepted tick keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted transfer");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result transfer changed");

  // At most one emitter group is lit, and none after a filter phase.
  a_led_pattern: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[2:0]) && (!m_tuser[0] || m_tdata[2:0] == 3'b000))
    else $error("bad emitter pattern");

  // Sensing results are a single, empty transfer.
  a_sensing_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[3:1] == 3'd0
      && m_tdata[34:3] == 32'd0)
    else $error("sensing result carries channel data");

endmodule

bind reflective_sensor_ambient_filter rsaf_checker u_rsaf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
